FILE: rtl/core/bsc_pkg.sv
// bsc_pkg: shared types, widths and constants of the barometric compensation unit
// no dependencies; imported by every rtl module
`default_nettype none

package bsc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_OVERSAMPLING = 3'd0,
        REG_CAL_AC1_AC2  = 3'd1,
        REG_CAL_AC3_AC4  = 3'd2,
        REG_CAL_AC5_AC6  = 3'd3,
        REG_CAL_B1_B2    = 3'd4,
        REG_CAL_MC_MD    = 3'd5
    } bsc_reg_idx_t;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_CLAMP    = 2'd2;

    // reset values of the calibration words
    localparam logic [31:0] RST_AC1_AC2 = 32'd4290249112;
    localparam logic [31:0] RST_AC3_AC4 = 32'd2145765329;
    localparam logic [31:0] RST_AC5_AC6 = 32'd1517387765;
    localparam logic [31:0] RST_B1_B2   = 32'd268334;
    localparam logic [31:0] RST_MC_MD   = 32'd188014073;

    // compensation constants
    localparam int          C_B6_OFFSET  = 4000;
    localparam int          C_B7_SCALE   = 50000;
    localparam logic [19:0] C_PMAX       = 20'hFFFFF;
    localparam logic [26:0] C_P_LIMIT    = 27'd16777216;

    // temperature divider: |mc*2048| over |x1+md|
    localparam int TQ_W = 27;
    localparam int TD_W = 20;
    localparam int TR_W = TQ_W + TD_W;

    // pressure divider: b7 (or 2*b7) over b4
    localparam int PQ_W = 26;
    localparam int PD_W = 40;
    localparam int PN_W = 63;
    localparam int PR_W = PQ_W + PD_W;

    typedef struct packed {
        logic [1:0]  oss;
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } bsc_cfg_t;

    // data riding along the temperature divider
    typedef struct packed {
        logic signed [19:0] x1;
        logic [23:0]        up;
        logic               zero;
        logic               neg;
    } bsc_tside_t;

    // data riding along the pressure divider
    typedef struct packed {
        logic signed [15:0] t;
        logic               doubled;
        logic               neg;
        logic               big;
        logic               err;
    } bsc_pside_t;

endpackage

`default_nettype wire

FILE: rtl/core/bsc_in_if.sv
// bsc_in_if: raw sample channel, valid/ready with temperature and pressure words
// depends on nothing
`default_nettype none

interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bsc_out_if.sv
// bsc_out_if: compensated result channel, valid/ready with temperature, pressure, status
// depends on nothing
`default_nettype none

interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic [19:0]        pressure;
    logic [1:0]         status;

    modport source (output valid, output temperature_tenths, output pressure,
                    output status, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bsc_cfg_if.sv
// bsc_cfg_if: configuration write channel, valid/ready with register index and data
// depends on nothing
`default_nettype none

interface bsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bsc_cfg_regs.sv
// bsc_cfg_regs: oversampling and calibration register file
// depends on bsc_pkg and bsc_cfg_if
`default_nettype none

module bsc_cfg_regs
    import bsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsc_cfg_if.sink    cfg,
    output bsc_cfg_t   cfg_q
);

    bsc_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.oss     <= 2'd0;
            cfg_reg.ac1_ac2 <= RST_AC1_AC2;
            cfg_reg.ac3_ac4 <= RST_AC3_AC4;
            cfg_reg.ac5_ac6 <= RST_AC5_AC6;
            cfg_reg.b1_b2   <= RST_B1_B2;
            cfg_reg.mc_md   <= RST_MC_MD;
        end
        else if (cfg.valid)
        begin
            unique case (bsc_reg_idx_t'(cfg.index))
                REG_OVERSAMPLING: cfg_reg.oss     <= cfg.data[1:0];
                REG_CAL_AC1_AC2:  cfg_reg.ac1_ac2 <= cfg.data;
                REG_CAL_AC3_AC4:  cfg_reg.ac3_ac4 <= cfg.data;
                REG_CAL_AC5_AC6:  cfg_reg.ac5_ac6 <= cfg.data;
                REG_CAL_B1_B2:    cfg_reg.b1_b2   <= cfg.data;
                REG_CAL_MC_MD:    cfg_reg.mc_md   <= cfg.data;
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bsc_div_t.sv
// bsc_div_t: pipelined restoring divider for the temperature term, one quotient bit per stage
// depends on bsc_pkg
`default_nettype none

module bsc_div_t
    import bsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [TQ_W-1:0]   num,
    input  wire logic [TD_W-1:0]   den,
    input  wire bsc_tside_t        side_in,
    output logic                   out_valid,
    output logic [TQ_W-1:0]        quot,
    output bsc_tside_t             side_out
);

    logic [TQ_W-1:0] valid_reg;
    logic [TR_W-1:0] rem_reg  [TQ_W];
    logic [TD_W-1:0] den_reg  [TQ_W];
    logic [TQ_W-1:0] quot_reg [TQ_W];
    bsc_tside_t      side_reg [TQ_W];

    for (genvar i = 0; i < TQ_W; i++)
    begin : g_stage
        logic [TR_W-1:0] rem_in;
        logic [TR_W-1:0] dsh;
        logic [TR_W-1:0] rem_next;
        logic [TD_W-1:0] den_in;
        logic [TQ_W-1:0] quot_in;
        logic [TQ_W-1:0] quot_next;
        bsc_tside_t      side_s;
        logic            valid_in;

        if (i == 0)
        begin : g_first
            assign rem_in   = TR_W'(num);
            assign den_in   = den;
            assign quot_in  = '0;
            assign side_s   = side_in;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quot_in  = quot_reg[i-1];
            assign side_s   = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign dsh = TR_W'(den_in) << (TQ_W - 1 - i);

        always_comb
        begin
            rem_next  = rem_in;
            quot_next = quot_in;
            if (rem_in >= dsh)
            begin
                rem_next                 = rem_in - dsh;
                quot_next[TQ_W - 1 - i]  = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quot_reg[i] <= quot_next;
                side_reg[i] <= side_s;
            end
        end
    end

    assign out_valid = valid_reg[TQ_W-1];
    assign quot      = quot_reg[TQ_W-1];
    assign side_out  = side_reg[TQ_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/bsc_div_p.sv
// bsc_div_p: pipelined restoring divider for the pressure term, one quotient bit per stage
// depends on bsc_pkg
`default_nettype none

module bsc_div_p
    import bsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [PN_W-1:0]   num,
    input  wire logic [PD_W-1:0]   den,
    input  wire bsc_pside_t        side_in,
    output logic                   out_valid,
    output logic [PQ_W-1:0]        quot,
    output bsc_pside_t             side_out
);

    logic [PQ_W-1:0] valid_reg;
    logic [PR_W-1:0] rem_reg  [PQ_W];
    logic [PD_W-1:0] den_reg  [PQ_W];
    logic [PQ_W-1:0] quot_reg [PQ_W];
    bsc_pside_t      side_reg [PQ_W];

    for (genvar i = 0; i < PQ_W; i++)
    begin : g_stage
        logic [PR_W-1:0] rem_in;
        logic [PR_W-1:0] dsh;
        logic [PR_W-1:0] rem_next;
        logic [PD_W-1:0] den_in;
        logic [PQ_W-1:0] quot_in;
        logic [PQ_W-1:0] quot_next;
        bsc_pside_t      side_s;
        logic            valid_in;

        if (i == 0)
        begin : g_first
            assign rem_in   = PR_W'(num);
            assign den_in   = den;
            assign quot_in  = '0;
            assign side_s   = side_in;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quot_in  = quot_reg[i-1];
            assign side_s   = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign dsh = PR_W'(den_in) << (PQ_W - 1 - i);

        always_comb
        begin
            rem_next  = rem_in;
            quot_next = quot_in;
            if (rem_in >= dsh)
            begin
                rem_next                = rem_in - dsh;
                quot_next[PQ_W - 1 - i] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quot_reg[i] <= quot_next;
                side_reg[i] <= side_s;
            end
        end
    end

    assign out_valid = valid_reg[PQ_W-1];
    assign quot      = quot_reg[PQ_W-1];
    assign side_out  = side_reg[PQ_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/barometric_sensor_compensation_unit.sv
// barometric_sensor_compensation_unit: top level, pipelined integer compensation datapath
// depends on bsc_pkg, bsc_in_if, bsc_out_if, bsc_cfg_if, bsc_cfg_regs, bsc_div_t, bsc_div_p
//
// channel  | dir | payload                                         | accepted when
// ---------+-----+-------------------------------------------------+----------------------
// sample   | in  | raw_temperature[15:0], raw_pressure[23:0]       | valid & ready
// result   | out | temperature_tenths[15:0] s, pressure[19:0],     | valid & ready
//          |     | status[1:0]                                     |
// cfg      | in  | index[2:0], data[31:0]                          | valid & ready
//
// one sample transaction per cycle while the pipeline is not stalled; most pipeline stages lie in the two
//   bit-per-stage dividers (27 stages for the temperature term, 26 for the pressure term)
// the whole pipeline advances together whenever the result register is empty or taken
// a stall freezes every stage, so nothing is lost or repeated
// reset clears all valid bits and loads the calibration defaults; cfg is always ready
`default_nettype none

module barometric_sensor_compensation_unit
    import bsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsc_in_if.sink     sample,
    bsc_out_if.source  result,
    bsc_cfg_if.sink    cfg
);

    // ---------------------------------------------------------------------
    // configuration and coefficient decode
    // ---------------------------------------------------------------------
    bsc_cfg_t cfg_q;

    bsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;
    logic signed [16:0] ac4s, ac5s;

    assign ac1  = cfg_q.ac1_ac2[15:0];
    assign ac2  = cfg_q.ac1_ac2[31:16];
    assign ac3  = cfg_q.ac3_ac4[15:0];
    assign ac4  = cfg_q.ac3_ac4[31:16];
    assign ac5  = cfg_q.ac5_ac6[15:0];
    assign ac6  = cfg_q.ac5_ac6[31:16];
    assign b1   = cfg_q.b1_b2[15:0];
    assign b2   = cfg_q.b1_b2[31:16];
    assign mc   = cfg_q.mc_md[15:0];
    assign md   = cfg_q.mc_md[31:16];
    assign ac4s = $signed({1'b0, ac4});
    assign ac5s = $signed({1'b0, ac5});

    // ---------------------------------------------------------------------
    // global advance: the pipeline moves when the result slot is free
    // ---------------------------------------------------------------------
    logic en;
    logic result_valid_reg;

    assign en           = !result_valid_reg || result.ready;
    assign sample.ready = en;

    // ---------------------------------------------------------------------
    // front: ut - ac6, x1, divider operands
    // ---------------------------------------------------------------------
    logic [2:0]         front_vld_reg;
    logic signed [17:0] s0_d_reg;
    logic [23:0]        s0_up_reg;
    logic signed [34:0] s1_prod;
    logic signed [19:0] s1_x1_reg;
    logic [23:0]        s1_up_reg;
    logic signed [20:0] s2_den_reg;
    logic signed [27:0] s2_num_reg;
    logic signed [19:0] s2_x1_reg;
    logic [23:0]        s2_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
        end
        else if (en)
        begin
            front_vld_reg <= {front_vld_reg[1:0], sample.valid};
        end
    end

    assign s1_prod = s0_d_reg * ac5s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // raw difference and oversampling-adjusted pressure word
            s0_d_reg   <= $signed({2'b00, sample.raw_temperature}) - $signed({2'b00, ac6});
            s0_up_reg  <= 24'(sample.raw_pressure >> (4'd8 - {2'b00, cfg_q.oss}));
            // x1 = (ut - ac6) * ac5 >> 15
            s1_x1_reg  <= 20'(s1_prod >>> 15);
            s1_up_reg  <= s0_up_reg;
            // divisor x1 + md and dividend mc * 2048
            s2_den_reg <= 21'(s1_x1_reg) + 21'(md);
            s2_num_reg <= 28'(mc) <<< 11;
            s2_x1_reg  <= s1_x1_reg;
            s2_up_reg  <= s1_up_reg;
        end
    end

    // magnitude division, sign restored afterwards (truncation toward zero)
    logic            t_zero;
    logic [TQ_W-1:0] t_num;
    logic [TD_W-1:0] t_den;
    bsc_tside_t      t_side_in;
    bsc_tside_t      t_side_out;
    logic            t_out_valid;
    logic [TQ_W-1:0] t_quot;

    assign t_zero = (s2_den_reg == 21'sd0);
    assign t_num  = s2_num_reg[27] ? TQ_W'(-s2_num_reg) : TQ_W'(s2_num_reg);

    always_comb
    begin
        if (t_zero)
        begin
            t_den = TD_W'(1);
        end
        else if (s2_den_reg[20])
        begin
            t_den = TD_W'(-s2_den_reg);
        end
        else
        begin
            t_den = TD_W'(s2_den_reg);
        end
    end

    assign t_side_in.x1   = s2_x1_reg;
    assign t_side_in.up   = s2_up_reg;
    assign t_side_in.zero = t_zero;
    assign t_side_in.neg  = s2_num_reg[27] ^ s2_den_reg[20];

    bsc_div_t u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_vld_reg[2]),
        .num       (t_num),
        .den       (t_den),
        .side_in   (t_side_in),
        .out_valid (t_out_valid),
        .quot      (t_quot),
        .side_out  (t_side_out)
    );

    // ---------------------------------------------------------------------
    // middle: b5, temperature, b3, b4, b7
    // ---------------------------------------------------------------------
    logic [7:0] mid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg <= '0;
        end
        else if (en)
        begin
            mid_vld_reg <= {mid_vld_reg[6:0], t_out_valid};
        end
    end

    // stage 3: b5, b6 and the saturated temperature
    logic signed [28:0] s3_x2;
    logic signed [28:0] s3_b5;
    logic signed [28:0] s3_tr;
    logic signed [15:0] s3_tsat;

    assign s3_x2 = t_side_out.neg ? -29'(t_quot) : 29'(t_quot);
    assign s3_b5 = 29'(t_side_out.x1) + s3_x2;
    assign s3_tr = (s3_b5 + 29'sd8) >>> 4;

    always_comb
    begin
        if (s3_tr > 29'sd32767)
        begin
            s3_tsat = 16'sh7FFF;
        end
        else if (s3_tr < -29'sd32768)
        begin
            s3_tsat = 16'sh8000;
        end
        else
        begin
            s3_tsat = 16'(s3_tr);
        end
    end

    logic signed [28:0] s3_b6_reg;
    logic signed [15:0] s3_t_reg;
    logic [23:0]        s3_up_reg;
    logic               s3_zero_reg;

    // stage 4: b6 squared and the two linear b6 terms
    logic signed [57:0] s4_b6sq;
    logic signed [44:0] s4_ac2b6;
    logic signed [44:0] s4_ac3b6;
    logic [41:0]        s4_sq_reg;
    logic signed [33:0] s4_x2a_reg;
    logic signed [33:0] s4_x1c_reg;
    logic signed [15:0] s4_t_reg;
    logic [23:0]        s4_up_reg;
    logic               s4_zero_reg;

    assign s4_b6sq  = s3_b6_reg * s3_b6_reg;
    assign s4_ac2b6 = s3_b6_reg * ac2;
    assign s4_ac3b6 = s3_b6_reg * ac3;

    // stage 5: b2 * sq and b1 * sq as two partial products each
    logic signed [21:0] s5_sq_hi;
    logic signed [21:0] s5_sq_lo;
    logic signed [37:0] s5_b2h_reg, s5_b2l_reg, s5_b1h_reg, s5_b1l_reg;
    logic signed [33:0] s5_x2a_reg;
    logic signed [33:0] s5_x1c_reg;
    logic signed [15:0] s5_t_reg;
    logic [23:0]        s5_up_reg;
    logic               s5_zero_reg;

    assign s5_sq_hi = $signed({1'b0, s4_sq_reg[41:21]});
    assign s5_sq_lo = $signed({1'b0, s4_sq_reg[20:0]});

    // stage 6: recombine partial products
    logic signed [59:0] s6_b2sq;
    logic signed [59:0] s6_b1sq;
    logic signed [48:0] s6_x1b_reg;
    logic signed [43:0] s6_x2c_reg;
    logic signed [33:0] s6_x2a_reg;
    logic signed [33:0] s6_x1c_reg;
    logic signed [15:0] s6_t_reg;
    logic [23:0]        s6_up_reg;
    logic               s6_zero_reg;

    assign s6_b2sq = (60'(s5_b2h_reg) <<< 21) + 60'(s5_b2l_reg);
    assign s6_b1sq = (60'(s5_b1h_reg) <<< 21) + 60'(s5_b1l_reg);

    // stage 7: b3 and the b4 operand x3 + 32768
    logic signed [49:0] s7_x3;
    logic signed [51:0] s7_base;
    logic signed [54:0] s7_sh;
    logic signed [45:0] s7_y;
    logic signed [45:0] s7_x3b;
    logic signed [52:0] s7_b3_reg;
    logic signed [44:0] s7_t3_reg;
    logic signed [15:0] s7_t_reg;
    logic [23:0]        s7_up_reg;
    logic               s7_zero_reg;

    assign s7_x3   = 50'(s6_x1b_reg) + 50'(s6_x2a_reg);
    assign s7_base = (52'(ac1) <<< 2) + 52'(s7_x3);
    assign s7_sh   = 55'(s7_base) <<< cfg_q.oss;
    assign s7_y    = 46'(s6_x1c_reg) + 46'(s6_x2c_reg) + 46'sd2;
    assign s7_x3b  = s7_y >>> 2;

    // stage 8: ac4 * (x3 + 32768) split, raw pressure minus b3
    logic signed [22:0] s8_t3_hi;
    logic signed [22:0] s8_t3_lo;
    logic signed [39:0] s8_ph_reg;
    logic signed [39:0] s8_pl_reg;
    logic signed [53:0] s8_diff_reg;
    logic signed [15:0] s8_t_reg;
    logic               s8_zero_reg;

    assign s8_t3_hi = 23'(s7_t3_reg >>> 22);
    assign s8_t3_lo = $signed({1'b0, s7_t3_reg[21:0]});

    // stage 9: b4 and b7
    logic signed [63:0] s9_b4full;
    logic [15:0]        s9_kscale;
    logic signed [16:0] s9_kmul;
    logic signed [70:0] s9_b7full;
    logic signed [43:0] s9_b4_reg;
    logic signed [63:0] s9_b7_reg;
    logic signed [15:0] s9_t_reg;
    logic               s9_zero_reg;

    assign s9_b4full = (64'(s8_ph_reg) <<< 22) + 64'(s8_pl_reg);
    assign s9_kscale = 16'(C_B7_SCALE >> cfg_q.oss);
    assign s9_kmul   = $signed({1'b0, s9_kscale});
    assign s9_b7full = s8_diff_reg * s9_kmul;

    // stage 10: pressure divider operands and flags
    logic            s10_err;
    logic            s10_neg;
    logic            s10_small;
    logic [PN_W-1:0] s10_num;
    logic [PD_W-1:0] s10_den;
    logic [PN_W-1:0] s10_num_reg;
    logic [PD_W-1:0] s10_den_reg;
    bsc_pside_t      s10_side_reg;

    assign s10_err   = s9_zero_reg || (s9_b4_reg <= 44'sd0);
    assign s10_neg   = s9_b7_reg[63];
    assign s10_small = (s9_b7_reg < 64'sd2147483648);

    always_comb
    begin
        if (s10_neg)
        begin
            s10_num = '0;
        end
        else if (s10_small)
        begin
            s10_num = PN_W'(s9_b7_reg) << 1;
        end
        else
        begin
            s10_num = PN_W'(s9_b7_reg);
        end
        s10_den = s10_err ? PD_W'(1) : s9_b4_reg[PD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_b6_reg    <= s3_b5 - 29'(C_B6_OFFSET);
            s3_t_reg     <= s3_tsat;
            s3_up_reg    <= t_side_out.up;
            s3_zero_reg  <= t_side_out.zero;

            s4_sq_reg    <= 42'(s4_b6sq >>> 12);
            s4_x2a_reg   <= 34'(s4_ac2b6 >>> 11);
            s4_x1c_reg   <= 34'(s4_ac3b6 >>> 13);
            s4_t_reg     <= s3_t_reg;
            s4_up_reg    <= s3_up_reg;
            s4_zero_reg  <= s3_zero_reg;

            s5_b2h_reg   <= s5_sq_hi * b2;
            s5_b2l_reg   <= s5_sq_lo * b2;
            s5_b1h_reg   <= s5_sq_hi * b1;
            s5_b1l_reg   <= s5_sq_lo * b1;
            s5_x2a_reg   <= s4_x2a_reg;
            s5_x1c_reg   <= s4_x1c_reg;
            s5_t_reg     <= s4_t_reg;
            s5_up_reg    <= s4_up_reg;
            s5_zero_reg  <= s4_zero_reg;

            s6_x1b_reg   <= 49'(s6_b2sq >>> 11);
            s6_x2c_reg   <= 44'(s6_b1sq >>> 16);
            s6_x2a_reg   <= s5_x2a_reg;
            s6_x1c_reg   <= s5_x1c_reg;
            s6_t_reg     <= s5_t_reg;
            s6_up_reg    <= s5_up_reg;
            s6_zero_reg  <= s5_zero_reg;

            s7_b3_reg    <= 53'((s7_sh + 55'sd2) >>> 2);
            s7_t3_reg    <= 45'(s7_x3b) + 45'sd32768;
            s7_t_reg     <= s6_t_reg;
            s7_up_reg    <= s6_up_reg;
            s7_zero_reg  <= s6_zero_reg;

            s8_ph_reg    <= s8_t3_hi * ac4s;
            s8_pl_reg    <= s8_t3_lo * ac4s;
            s8_diff_reg  <= 54'($signed({1'b0, s7_up_reg})) - 54'(s7_b3_reg);
            s8_t_reg     <= s7_t_reg;
            s8_zero_reg  <= s7_zero_reg;

            s9_b4_reg    <= 44'(s9_b4full >>> 15);
            s9_b7_reg    <= 64'(s9_b7full);
            s9_t_reg     <= s8_t_reg;
            s9_zero_reg  <= s8_zero_reg;

            s10_num_reg          <= s10_num;
            s10_den_reg          <= s10_den;
            s10_side_reg.t       <= s9_t_reg;
            s10_side_reg.doubled <= s10_small;
            s10_side_reg.neg     <= s10_neg;
            // quotient would not fit the divider: certainly above the pressure limit
            s10_side_reg.big     <= ((s10_num >> PQ_W) >= PN_W'(s10_den));
            s10_side_reg.err     <= s10_err;
        end
    end

    // ---------------------------------------------------------------------
    // pressure division
    // ---------------------------------------------------------------------
    logic            p_out_valid;
    logic [PQ_W-1:0] p_quot;
    bsc_pside_t      p_side;

    bsc_div_p u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_vld_reg[7]),
        .num       (s10_num_reg),
        .den       (s10_den_reg),
        .side_in   (s10_side_reg),
        .out_valid (p_out_valid),
        .quot      (p_quot),
        .side_out  (p_side)
    );

    // ---------------------------------------------------------------------
    // back: second-order pressure correction and clamping
    // ---------------------------------------------------------------------
    logic [1:0] back_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_vld_reg <= '0;
        end
        else if (en)
        begin
            back_vld_reg <= {back_vld_reg[0], p_out_valid};
        end
    end

    // stage 11: undo the doubling choice, square and linear terms
    logic [26:0]        s11_p0;
    logic [16:0]        s11_ph;
    logic [26:0]        s11_p0_reg;
    logic [33:0]        s11_sq8_reg;
    logic signed [41:0] s11_m_reg;
    logic               s11_over_reg;
    bsc_pside_t         s11_side_reg;

    assign s11_p0 = p_side.doubled ? {1'b0, p_quot} : {p_quot, 1'b0};
    assign s11_ph = s11_p0[24:8];

    // stage 12: scale the square term
    logic [45:0]        s12_prod;
    logic [28:0]        s12_x1_reg;
    logic signed [25:0] s12_x2_reg;
    logic [26:0]        s12_p0_reg;
    logic               s12_over_reg;
    bsc_pside_t         s12_side_reg;

    assign s12_prod = s11_sq8_reg * 46'd3038;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_p0_reg   <= s11_p0;
            s11_sq8_reg  <= s11_ph * s11_ph;
            s11_m_reg    <= 42'sd0 - ($signed({15'b0, s11_p0}) * 42'sd7357);
            s11_over_reg <= p_side.big || (s11_p0 > C_P_LIMIT);
            s11_side_reg <= p_side;

            s12_x1_reg   <= 29'(s12_prod >> 16);
            s12_x2_reg   <= 26'(s11_m_reg >>> 16);
            s12_p0_reg   <= s11_p0_reg;
            s12_over_reg <= s11_over_reg;
            s12_side_reg <= s11_side_reg;
        end
    end

    // final sum, clamp and status selection
    logic signed [30:0] s13_sum;
    logic signed [30:0] s13_pf;
    logic signed [15:0] s13_t;
    logic [19:0]        s13_p;
    logic [1:0]         s13_st;

    assign s13_sum = 31'($signed({1'b0, s12_x1_reg})) + 31'(s12_x2_reg) + 31'sd3791;
    assign s13_pf  = 31'($signed({1'b0, s12_p0_reg})) + (s13_sum >>> 4);

    always_comb
    begin
        s13_t  = s12_side_reg.t;
        s13_p  = s13_pf[19:0];
        s13_st = ST_OK;
        if (s12_side_reg.err)
        begin
            s13_t  = '0;
            s13_p  = '0;
            s13_st = ST_DIV_ZERO;
        end
        else if (s12_side_reg.neg)
        begin
            s13_p  = '0;
            s13_st = ST_CLAMP;
        end
        else if (s12_over_reg)
        begin
            s13_p  = C_PMAX;
            s13_st = ST_CLAMP;
        end
        else if (s13_pf < 31'sd0)
        begin
            s13_p  = '0;
            s13_st = ST_CLAMP;
        end
        else if (s13_pf > 31'($signed({1'b0, C_PMAX})))
        begin
            s13_p  = C_PMAX;
            s13_st = ST_CLAMP;
        end
    end

    // ---------------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------------
    logic signed [15:0] result_t_reg;
    logic [19:0]        result_p_reg;
    logic [1:0]         result_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= back_vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_t_reg  <= s13_t;
            result_p_reg  <= s13_p;
            result_st_reg <= s13_st;
        end
    end

    assign result.valid              = result_valid_reg;
    assign result.temperature_tenths = result_t_reg;
    assign result.pressure           = result_p_reg;
    assign result.status             = result_st_reg;

endmodule

`default_nettype wire
